// ===== design/sha_pkg.sv =====
// package: constants, types and round functions for the sha-256 hasher
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PadLimit   = 56;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // byte source for a buffer write
  typedef enum logic [1:0] {
    SrcData,
    SrcPad,
    SrcZero,
    SrcLen
  } byte_src_e;

  typedef struct packed {
    logic      wr_byte;
    byte_src_e src;
    logic      add_bits;
    logic      rnd_init;
    logic      rnd_step;
    logic      hash_add;
    logic      restart;
  } ctl_cmd_t;

  typedef struct packed {
    logic [6:0] fill;
    logic [5:0] rnd;
  } ctl_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== design/sha_stream_if.sv =====
// valid/ready channel interfaces for the input and digest streams
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       has_byte;
  logic       last;
  modport source (output valid, data, has_byte, last, input ready);
  modport sink   (input valid, data, has_byte, last, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/sha_datapath.sv =====
// buffer, counters, schedule and round datapath of the hasher
module sha_datapath import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_cmd_t   cmd_i,
  input  logic [7:0] data_i,
  input  logic [2:0] rd_idx_i,
  output ctl_sts_t   sts_o,
  output logic [31:0] hash_word_o
);

  logic [31:0] buf_q [16];
  logic [6:0]  fill_q, fill_d;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [7:0]  wbyte;
  logic [2:0]  len_idx;
  logic [31:0] w_cur, s0, s1, t1, t2;

  assign len_idx = fill_q[2:0];

  always_comb begin
    case (cmd_i.src)
      SrcData: wbyte = data_i;
      SrcPad:  wbyte = PadByte;
      SrcZero: wbyte = 8'h00;
      default: wbyte = bits_q[63 - 8 * len_idx -: 8];
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.restart) begin
      fill_d = '0;
    end else if (cmd_i.wr_byte) begin
      fill_d = (fill_q == 7'(BlockBytes - 1)) ? 7'(BlockBytes) : fill_q + 7'd1;
    end else if (cmd_i.hash_add) begin
      fill_d = '0;
    end
  end

  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_cur = w_q[0];
  assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_cur;
  assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      h_q    <= InitHash;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.restart) begin
        bits_q <= '0;
        h_q    <= InitHash;
      end else begin
        if (cmd_i.add_bits) begin
          bits_q <= bits_q + 64'd8;
        end
        if (cmd_i.hash_add) begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
        end
      end
      if (cmd_i.rnd_init) begin
        rnd_q <= '0;
      end else if (cmd_i.rnd_step) begin
        rnd_q <= rnd_q + 6'd1;
      end
    end
  end

  // bytes packed big-endian into the sixteen block words
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      buf_q[fill_q[5:2]][31 - 8 * fill_q[1:0] -: 8] <= wbyte;
    end
    if (cmd_i.rnd_init) begin
      w_q <= buf_q;
      v_q <= h_q;
    end else if (cmd_i.rnd_step) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign sts_o.fill = fill_q;
  assign sts_o.rnd  = rnd_q;
  assign hash_word_o = h_q[rd_idx_i];

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 7'(BlockBytes)) else $error("fill out of range");
  a_round_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rnd_step && rnd_q == 6'd63 |=> rnd_q == 6'd0) else $error("round count slip");
  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr_byte && cmd_i.rnd_step)) else $error("write during rounds");
`endif

endmodule

// ===== design/sha_ctrl.sv =====
// controller state machine: byte intake, padding, rounds and digest output
module sha_ctrl import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       has_byte_i,
  input  logic       last_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [2:0] word_idx_o,
  input  ctl_sts_t   sts_i,
  output ctl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StPadMark,
    StPadFill,
    StRounds,
    StAdd,
    StOut
  } state_e;

  state_e     state_q;
  logic       final_q;
  logic       split_q;
  logic       pend_q;
  logic [2:0] idx_q;

  logic acc;
  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign word_idx_o  = idx_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.src = SrcData;
    unique case (state_q)
      StIdle: begin
        if (acc && has_byte_i) begin
          cmd_o.wr_byte  = 1'b1;
          cmd_o.add_bits = 1'b1;
        end
      end
      StPadMark: begin
        if (sts_i.fill == 7'(BlockBytes)) begin
          cmd_o.rnd_init = 1'b1;
        end else begin
          cmd_o.wr_byte = 1'b1;
          cmd_o.src     = SrcPad;
        end
      end
      StPadFill: begin
        if (sts_i.fill == 7'(BlockBytes)) begin
          cmd_o.rnd_init = 1'b1;
        end else begin
          cmd_o.wr_byte = 1'b1;
          cmd_o.src = (final_q && sts_i.fill >= 7'(PadLimit)) ? SrcLen : SrcZero;
        end
      end
      StRounds: cmd_o.rnd_step = 1'b1;
      StAdd:    cmd_o.hash_add = 1'b1;
      StOut:    cmd_o.restart  = out_ready_i && idx_q == 3'd7;
      default:  cmd_o = '0;
    endcase
  end

  // final_q: block in work ends the message
  // split_q: first of two padding blocks
  // pend_q: last word waits behind a full-block compress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      final_q <= 1'b0;
      split_q <= 1'b0;
      pend_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            final_q <= 1'b0;
            split_q <= 1'b0;
            pend_q  <= last_i;
            if ((has_byte_i && sts_i.fill == 7'(BlockBytes - 1)) || last_i) begin
              state_q <= StPadMark;
            end
          end
        end
        StPadMark: begin
          if (sts_i.fill == 7'(BlockBytes)) begin
            state_q <= StRounds;
          end else begin
            final_q <= (sts_i.fill < 7'(PadLimit));
            split_q <= (sts_i.fill >= 7'(PadLimit));
            pend_q  <= 1'b0;
            state_q <= StPadFill;
          end
        end
        StPadFill: begin
          if (sts_i.fill == 7'(BlockBytes)) begin
            state_q <= StRounds;
          end
        end
        StRounds: begin
          if (sts_i.rnd == 6'(Rounds - 1)) begin
            state_q <= StAdd;
          end
        end
        StAdd: begin
          if (final_q) begin
            state_q <= StOut;
            idx_q   <= '0;
          end else if (split_q) begin
            state_q <= StPadFill;
            final_q <= 1'b1;
            split_q <= 1'b0;
          end else if (pend_q) begin
            state_q <= StPadMark;
            pend_q  <= 1'b0;
          end else begin
            state_q <= StIdle;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q <= StIdle;
              final_q <= 1'b0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_out_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> word_idx_o == 3'd0) else $error("digest starts off word zero");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input open during output");
  a_idle_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && word_idx_o == 3'd7 |=> in_ready_o)
    else $error("no return to idle");
`endif

endmodule

// ===== design/sha256_stream_hasher_core.sv =====
// top level of the streaming sha-256 hasher
//  channel | dir | payload
//  in_w    | in  | data[7:0], has_byte, last
//  out_w   | out | digest_word[31:0], word_index[2:0], last_word
// a byte word is written as it is taken; a full block adds one load, 64 round and one add step
// a last word adds padding (up to 72 byte writes) and one or two compressions
// then eight digest words, each held until taken
// input is closed outside idle: while padding, while a block compresses or while the digest is out
// reset restores the initial hash values and clears counts
module sha256_stream_hasher_core import sha_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  sha_in_if.sink   in_w,
  sha_out_if.source out_w
);

  ctl_cmd_t   cmd;
  ctl_sts_t   sts;
  logic [2:0] idx;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_w.valid),
    .in_ready_o  (in_w.ready),
    .has_byte_i  (in_w.has_byte),
    .last_i      (in_w.last),
    .out_ready_i (out_w.ready),
    .out_valid_o (out_w.valid),
    .word_idx_o  (idx),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sha_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_i      (in_w.data),
    .rd_idx_i    (idx),
    .sts_o       (sts),
    .hash_word_o (out_w.digest_word)
  );

  assign out_w.word_index = idx;
  assign out_w.last_word  = (idx == 3'd7);

endmodule

// ===== tb/testbench.sv =====
// testbench for the streaming sha-256 hasher: directed table and random messages
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  typedef struct {
    in_word_t    w;
    logic        known;
    logic [31:0] d0;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha_in_if  in_w ();
  sha_out_if out_w ();

  sha256_stream_hasher_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_w  (in_w.sink),
    .out_w (out_w.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] h_q [8];
  logic [7:0]  buf_q [64];
  int unsigned fill_q;
  logic [63:0] len_bits_q;

  digest_t     digest_q [$];
  logic [31:0] known_d0_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          ready_hold_off = 1'b0;

  function automatic void restart_msg();
    for (int i = 0; i < 8; i++) h_q[i] = InitHash[i];
    fill_q = 0;
    len_bits_q = '0;
  endfunction

  function automatic void compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] x, s0, s1, t1, t2, w2, w15;
    for (int i = 0; i < 16; i++)
      w[i] = {buf_q[4*i], buf_q[4*i+1], buf_q[4*i+2], buf_q[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = h_q[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        x = w[i];
      end else begin
        w2  = w[(i-2) & 15];
        w15 = w[(i-15) & 15];
        s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        x = s1 + w[(i-7) & 15] + s0 + w[i & 15];
        w[i & 15] = x;
      end
      t1 = v[7] + ({v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
           ^ {v[4][24:0], v[4][31:25]}) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
           + RoundK[i] + x;
      t2 = ({v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
           ^ {v[0][21:0], v[0][31:22]})
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h_q[i] += v[i];
  endfunction

  function automatic void predict_digest(in_word_t w);
    if (w.has_byte) begin
      buf_q[fill_q] = w.data;
      fill_q++;
      len_bits_q += 64'd8;
      if (fill_q == 64) begin
        compress();
        fill_q = 0;
      end
    end
    if (!w.last) return;
    buf_q[fill_q] = PadByte;
    fill_q++;
    if (fill_q > PadLimit) begin
      while (fill_q < 64) buf_q[fill_q++] = 8'h00;
      compress();
      fill_q = 0;
    end
    while (fill_q < PadLimit) buf_q[fill_q++] = 8'h00;
    for (int i = 0; i < 8; i++) buf_q[PadLimit+i] = len_bits_q[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) digest_q.push_back({h_q[i], 3'(i), i == 7});
    restart_msg();
  endfunction

  task automatic send(in_word_t w);
    in_w.valid    <= 1'b1;
    in_w.data     <= w.data;
    in_w.has_byte <= w.has_byte;
    in_w.last     <= w.last;
    do @(posedge clk_i); while (!in_w.ready);
    predict_digest(w);
    if ($urandom_range(0, 3) == 0) begin
      in_w.valid <= 1'b0;
      in_w.data  <= 8'($urandom);
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
  endtask

  task automatic send_msg(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send({8'($urandom), 1'b0, 1'b0});
      send({8'($urandom), 1'b1, 1'b0});
    end
    if ($urandom_range(0, 2) == 0) send({8'($urandom), 1'b0, 1'b1});
    else send({8'($urandom), 1'b1, 1'b1});
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_w.valid && out_w.ready) begin
        if (digest_q.size() == 0) begin
          if (errors < 10) $display("unexpected digest word %h", out_w.digest_word);
          errors++;
        end else begin
          digest_t e, a;
          e = digest_q.pop_front();
          a = {out_w.digest_word, out_w.word_index, out_w.last_word};
          if (e.word_index == 0 && known_d0_q.size() > 0) begin
            if (known_d0_q.pop_front() != e.digest_word) begin
              if (errors < 10) $display("table mismatch: predictor %h", e.digest_word);
              errors++;
            end
          end
          if (a != e) begin
            if (errors < 10)
              $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", e.digest_word,
                       e.word_index, e.last_word, a.digest_word, a.word_index,
                       a.last_word);
            errors++;
          end
        end
      end
      if (ready_hold_off) out_w.ready <= 1'b1;
      else out_w.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 20000) begin
      $display("[sha256_stream_hasher_core] ERROR");
      $finish;
    end
  end

  row_t table_rows [$];

  initial begin
    in_w.valid = 1'b0;
    in_w.data = 8'h00;
    in_w.has_byte = 1'b0;
    in_w.last = 1'b0;
    out_w.ready = 1'b0;
    restart_msg();
    for (int i = 0; i < 64; i++) buf_q[i] = 8'h00;
    // idle word, empty message (data ignored without has_byte), "abc", 0x00, 0xff
    table_rows.push_back('{'{8'hff, 1'b0, 1'b0}, 1'b0, 32'h0});
    table_rows.push_back('{'{8'h5a, 1'b0, 1'b1}, 1'b1, 32'he3b0c442});
    table_rows.push_back('{'{8'h61, 1'b1, 1'b0}, 1'b0, 32'h0});
    table_rows.push_back('{'{8'h62, 1'b1, 1'b0}, 1'b0, 32'h0});
    table_rows.push_back('{'{8'h63, 1'b1, 1'b1}, 1'b1, 32'hba7816bf});
    table_rows.push_back('{'{8'h00, 1'b1, 1'b1}, 1'b0, 32'h0});
    table_rows.push_back('{'{8'hff, 1'b1, 1'b0}, 1'b0, 32'h0});
    table_rows.push_back('{'{8'hff, 1'b0, 1'b1}, 1'b0, 32'h0});
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[r]) begin
      if (table_rows[r].known) known_d0_q.push_back(table_rows[r].d0);
      send(table_rows[r].w);
    end
    // padding edges: 55, 56, 63, 64 bytes, each plus a last word that may carry one more
    send_msg(55);
    send_msg(56);
    send_msg(63);
    send_msg(64);
    in_w.valid <= 1'b0;
    ready_hold_off <= 1'b1;
    wait (digest_q.size() == 0);
    ready_hold_off <= 1'b0;
    for (int n = 0; n < 9; n++)
      send_msg($urandom_range(0, 9) == 0 ? $urandom_range(60, 130) : $urandom_range(0, 12));
    in_w.valid <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("[sha256_stream_hasher_core] OK");
    end else begin
      $display("[sha256_stream_hasher_core] ERROR");
    end
    $finish;
  end
endmodule
